>>> src/single_qubit_gate_apply_defines.svh
// Assertion macros shared by the single-qubit gate engine.
// Needs clk and arst_n in the scope where the macros are used.
`ifndef SINGLE_QUBIT_GATE_APPLY_DEFINES_SVH
`define SINGLE_QUBIT_GATE_APPLY_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define SQG_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset
`define SQG_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> src/sqg_pkg.sv
// Types and constants of the single-qubit gate engine.
// No dependencies; used by the sequencer, the MAC unit and the top level.
`default_nettype none

package sqg_pkg;

	// Item kinds
	localparam logic [1:0] KIND_WRITE = 2'd0;
	localparam logic [1:0] KIND_APPLY = 2'd1;
	localparam logic [1:0] KIND_READ  = 2'd2;

	// Configuration port
	localparam int NUM_REGS = 8;
	localparam int CFG_AW   = 5;

	// Gate coefficients, index order u00_re, u00_im, u01_re, ... u11_im
	typedef logic [NUM_REGS-1:0][15:0] coef_t;

	// Reset gate: scaled Hadamard (11585 = 1/sqrt2 in Q2.14)
	localparam coef_t REG_RESET = {
		16'h0000, 16'hD2BF, 16'h0000, 16'h2D41,
		16'h0000, 16'h2D41, 16'h0000, 16'h2D41
	};

	// One multiply-accumulate step issued to the shared unit
	typedef struct packed {
		logic        vld;
		logic        clr;   // first term of a sum
		logic        neg;   // subtract this product
		logic        last;  // last term of a sum
		logic        comp;  // 0 real, 1 imaginary
		logic        row;   // gate row, selects output amplitude
		logic [15:0] coef;
		logic [15:0] amp;
	} mac_req_t;

	// Finished, rounded and saturated component
	typedef struct packed {
		logic        done;
		logic        comp;
		logic        row;
		logic        sat;
		logic [15:0] val;
	} mac_res_t;

endpackage

`default_nettype wire

>>> src/sqg_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module sqg_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

>>> src/sqg_mac.sv
// Shared complex-term multiply-accumulate unit: one 16x16 multiplier,
// a 34-bit accumulator and round-to-nearest / saturate. Uses sqg_pkg.
`default_nettype none

module sqg_mac (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire sqg_pkg::mac_req_t req,
	output sqg_pkg::mac_res_t      res
);

	logic               vld_s1, clr_s1, neg_s1, last_s1, comp_s1, row_s1;
	logic signed [31:0] prod_s1;
	logic               done_s2, comp_s2, row_s2;
	logic signed [33:0] acc_q;
	logic signed [33:0] addend;
	logic signed [33:0] base;
	logic signed [33:0] rnd;
	logic signed [19:0] shr;
	logic               sat_hi, sat_lo;

	// Stage 1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= req.vld;
		end
	end

	// Stage 1 product
	always_ff @(posedge clk) begin
		prod_s1 <= $signed(req.coef) * $signed(req.amp);
		clr_s1  <= req.clr;
		neg_s1  <= req.neg;
		last_s1 <= req.last;
		comp_s1 <= req.comp;
		row_s1  <= req.row;
	end

	// Stage 2 accumulate
	assign addend = neg_s1 ? -34'(prod_s1) : 34'(prod_s1);
	assign base   = clr_s1 ? 34'sd0 : acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_s2 <= 1'b0;
		end else begin
			done_s2 <= vld_s1 & last_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (vld_s1) begin
			acc_q <= base + addend;
		end
		comp_s2 <= comp_s1;
		row_s2  <= row_s1;
	end

	// Q6.28 -> Q2.14, nearest with ties up, then clamp
	assign rnd    = acc_q + 34'sd8192;
	assign shr    = rnd[33:14];
	assign sat_hi = shr > 20'sd32767;
	assign sat_lo = shr < -20'sd32768;

	always_comb begin
		res.done = done_s2;
		res.comp = comp_s2;
		res.row  = row_s2;
		res.sat  = done_s2 & (sat_hi | sat_lo);
		if (sat_hi) begin
			res.val = 16'h7FFF;
		end else if (sat_lo) begin
			res.val = 16'h8000;
		end else begin
			res.val = shr[15:0];
		end
	end

endmodule

`default_nettype wire

>>> src/sqg_ctrl.sv
// Sequencer: item decode, amplitude pair walk, operand selection for the
// shared MAC and state-vector RAM addressing. Uses sqg_pkg.
`default_nettype none

module sqg_ctrl #(
	parameter int NUM_QUBITS = 10
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   start,
	input  wire logic [1:0]             kind,
	input  wire logic [9:0]             amp_index,
	input  wire logic [3:0]             target_bit,
	input  wire logic [15:0]            write_re,
	input  wire logic [15:0]            write_im,
	input  wire sqg_pkg::coef_t         coefs,
	output logic                        busy,
	output logic                        done,
	output logic [15:0]                 read_re,
	output logic [15:0]                 read_im,
	output logic                        saturated,
	output sqg_pkg::mac_req_t           mac_req,
	input  wire sqg_pkg::mac_res_t      mac_res,
	output logic                        mem_we,
	output logic [NUM_QUBITS-1:0]       mem_waddr,
	output logic [31:0]                 mem_wdata,
	output logic [NUM_QUBITS-1:0]       mem_raddr,
	input  wire logic [31:0]            mem_rdata
);

	localparam int AW = NUM_QUBITS;
	localparam logic [AW-1:0] LAST_PAIR = AW'((1 << (AW - 1)) - 1);

	// Sequencer states
	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_WR   = 4'd1;
	localparam logic [3:0] S_RDA  = 4'd2;
	localparam logic [3:0] S_RDD  = 4'd3;
	localparam logic [3:0] S_NOP  = 4'd4;
	localparam logic [3:0] S_RD0  = 4'd5;
	localparam logic [3:0] S_RD1  = 4'd6;
	localparam logic [3:0] S_LAT  = 4'd7;
	localparam logic [3:0] S_MAC  = 4'd8;
	localparam logic [3:0] S_DR1  = 4'd9;
	localparam logic [3:0] S_DR2  = 4'd10;

	logic [3:0]    state_q;
	logic [AW-1:0] idx_q;
	logic [3:0]    tbit_q;
	logic [15:0]   wre_q, wim_q;
	logic [AW-1:0] pc_q;
	logic [3:0]    step_q;
	logic [31:0]   a0_q, a1_q;
	logic [15:0]   re_hold_q;
	logic          sat_q;
	logic          done_q, sat_out_q;
	logic [15:0]   rre_q, rim_q;

	logic          accept;
	logic [AW-1:0] low_mask, tmask, i0, i1;
	logic [1:0]    term;
	logic          comp, row, part_im;
	logic [31:0]   amp_word;

	assign accept = start & (state_q == S_IDLE);
	assign busy   = state_q != S_IDLE;

	// Pair addresses: insert a zero at the target bit of the pair count
	assign tmask    = AW'(1) << tbit_q;
	assign low_mask = tmask - AW'(1);
	assign i0       = ((pc_q & ~low_mask) << 1) | (pc_q & low_mask);
	assign i1       = i0 | tmask;

	// Operand selection for the current product term
	assign term     = step_q[1:0];
	assign comp     = step_q[2];
	assign row      = step_q[3];
	assign part_im  = term[0] ^ comp;
	assign amp_word = term[1] ? a1_q : a0_q;

	always_comb begin
		mac_req.vld  = state_q == S_MAC;
		mac_req.clr  = term == 2'd0;
		mac_req.neg  = ~comp & term[0];
		mac_req.last = term == 2'd3;
		mac_req.comp = comp;
		mac_req.row  = row;
		mac_req.coef = coefs[{row, term}];
		mac_req.amp  = part_im ? amp_word[31:16] : amp_word[15:0];
	end

	// RAM ports
	always_comb begin
		mem_raddr = idx_q;
		if (state_q == S_RD0) begin
			mem_raddr = i0;
		end else if (state_q == S_RD1) begin
			mem_raddr = i1;
		end
		if (state_q == S_WR) begin
			mem_we    = 1'b1;
			mem_waddr = idx_q;
			mem_wdata = {wim_q, wre_q};
		end else begin
			mem_we    = mac_res.done & mac_res.comp;
			mem_waddr = mac_res.row ? i1 : i0;
			mem_wdata = {mac_res.val, re_hold_q};
		end
	end

	// Sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						case (kind)
							sqg_pkg::KIND_WRITE: state_q <= S_WR;
							sqg_pkg::KIND_READ:  state_q <= S_RDA;
							sqg_pkg::KIND_APPLY: begin
								state_q <= (32'(target_bit) < NUM_QUBITS) ? S_RD0 : S_NOP;
							end
							default: state_q <= S_NOP;
						endcase
					end
				end
				S_WR, S_RDD, S_NOP: begin
					state_q <= S_IDLE;
					done_q  <= 1'b1;
				end
				S_RDA: state_q <= S_RDD;
				S_RD0: state_q <= S_RD1;
				S_RD1: state_q <= S_LAT;
				S_LAT: state_q <= S_MAC;
				S_MAC: begin
					if (step_q == 4'd15) begin
						state_q <= S_DR1;
					end
				end
				S_DR1: state_q <= S_DR2;
				S_DR2: begin
					if (pc_q == LAST_PAIR) begin
						state_q <= S_IDLE;
						done_q  <= 1'b1;
					end else begin
						state_q <= S_RD0;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Item fields, pair walk and result data
	always_ff @(posedge clk) begin
		if (accept) begin
			idx_q  <= AW'(amp_index);
			tbit_q <= target_bit;
			wre_q  <= write_re;
			wim_q  <= write_im;
			pc_q   <= '0;
			sat_q  <= 1'b0;
		end
		if (state_q == S_RD1) begin
			a0_q <= mem_rdata;
		end
		if (state_q == S_LAT) begin
			a1_q   <= mem_rdata;
			step_q <= 4'd0;
		end
		if (state_q == S_MAC) begin
			step_q <= step_q + 4'd1;
		end
		if (state_q == S_DR2) begin
			pc_q <= pc_q + AW'(1);
		end
		// finished components from the MAC
		if (mac_res.done) begin
			sat_q <= sat_q | mac_res.sat;
			if (!mac_res.comp) begin
				re_hold_q <= mac_res.val;
			end
		end
		// result data
		if (state_q == S_RDD) begin
			rre_q     <= mem_rdata[15:0];
			rim_q     <= mem_rdata[31:16];
			sat_out_q <= 1'b0;
		end else if (state_q == S_DR2) begin
			rre_q     <= 16'h0000;
			rim_q     <= 16'h0000;
			sat_out_q <= sat_q | mac_res.sat;
		end else if (state_q == S_WR || state_q == S_NOP) begin
			rre_q     <= 16'h0000;
			rim_q     <= 16'h0000;
			sat_out_q <= 1'b0;
		end
	end

	assign done      = done_q;
	assign read_re   = rre_q;
	assign read_im   = rim_q;
	assign saturated = sat_out_q;

endmodule

`default_nettype wire

>>> src/single_qubit_gate_apply.sv
// Single-qubit gate engine over a 2^NUM_QUBITS complex Q2.14 state vector.
// Strobe (done) rises when the item is finished: write passes S_WR, read S_RDA
// and S_RDD; an apply walks every amplitude pair with 2 RAM reads, 16 products
// through the one shared multiplier and a drain (S_DR1, S_DR2). busy falls
// with done, so the next start may follow at once; the receiver cannot stall.
// Reset clears control state and loads the gate registers; RAM is undefined.
`default_nettype none
`include "single_qubit_gate_apply_defines.svh"

module single_qubit_gate_apply #(
	parameter int NUM_QUBITS = 10
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	// command channel
	input  wire logic                       start,
	output logic                            busy,
	input  wire logic [1:0]                 kind,
	input  wire logic [9:0]                 amp_index,
	input  wire logic [3:0]                 target_bit,
	input  wire logic [15:0]                write_re,
	input  wire logic [15:0]                write_im,
	// results
	output logic                            done,
	output logic [15:0]                     read_re,
	output logic [15:0]                     read_im,
	output logic                            saturated,
	// configuration port
	input  wire logic                       psel,
	input  wire logic                       penable,
	input  wire logic                       pwrite,
	input  wire logic [sqg_pkg::CFG_AW-1:0] paddr,
	input  wire logic [31:0]                pwdata,
	output logic [31:0]                     prdata,
	output logic                            pready
);

	sqg_pkg::coef_t    coefs_q;
	sqg_pkg::mac_req_t mac_req;
	sqg_pkg::mac_res_t mac_res;
	logic                  mem_we;
	logic [NUM_QUBITS-1:0] mem_waddr, mem_raddr;
	logic [31:0]           mem_wdata, mem_rdata;
	logic                  cfg_wr;

	// Gate registers
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coefs_q <= sqg_pkg::REG_RESET;
		end else if (cfg_wr) begin
			coefs_q[paddr[4:2]] <= pwdata[15:0];
		end
	end

	assign prdata = {16'h0000, coefs_q[paddr[4:2]]};

	// Sequencer
	sqg_ctrl #(
		.NUM_QUBITS(NUM_QUBITS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.kind      (kind),
		.amp_index (amp_index),
		.target_bit(target_bit),
		.write_re  (write_re),
		.write_im  (write_im),
		.coefs     (coefs_q),
		.busy      (busy),
		.done      (done),
		.read_re   (read_re),
		.read_im   (read_im),
		.saturated (saturated),
		.mac_req   (mac_req),
		.mac_res   (mac_res),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata)
	);

	// Shared multiply-accumulate unit
	sqg_mac u_mac (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (mac_req),
		.res   (mac_res)
	);

	// State vector
	sqg_ram #(
		.WIDTH(32),
		.DEPTH(1 << NUM_QUBITS)
	) u_ram (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	// Checks
	`SQG_ASSERT_IMP(a_done_not_busy, done, !busy, "result strobe while busy")
	`SQG_ASSERT_NXT(a_done_single, done, !done, "result strobe held two cycles")
	`SQG_ASSERT_NXT(a_accept_busy, start && !busy, busy, "transfer accepted but not busy")
	`SQG_ASSERT_IMP(a_mac_in_item, mac_res.done, busy, "MAC result outside an apply")

endmodule

`default_nettype wire

>>> sim/testbench.sv
// Self-checking testbench for single_qubit_gate_apply: command transfers are
// predicted against a behavioural copy of the state vector and gate registers.
// Depends on sqg_pkg and the block's RTL only.

module testbench;

	// Full-size vector; one apply walks 512 pairs
	localparam int NQ          = 10;
	localparam int VEC_LEN     = 1 << NQ;
	localparam int CYCLE_LIMIT = 20_000_000;
	localparam int MAX_GAP     = 40;
	localparam int ADDR_W      = sqg_pkg::CFG_AW;
	localparam int NREGS       = sqg_pkg::NUM_REGS;

	// Kind with no meaning: the block must answer all zeros
	localparam logic [1:0] KIND_NONE = 2'd3;

	typedef enum int {
		REG_U00_RE, REG_U00_IM, REG_U01_RE, REG_U01_IM,
		REG_U10_RE, REG_U10_IM, REG_U11_RE, REG_U11_IM
	} gate_reg_t;

	typedef logic signed [15:0] q14_t;
	typedef q14_t gate_set_t [NREGS];

	typedef struct packed {
		logic [1:0]  kind;
		logic [9:0]  amp_index;
		logic [3:0]  target_bit;
		logic [15:0] write_re;
		logic [15:0] write_im;
	} gate_cmd_t;

	typedef struct packed {
		logic [15:0] re;
		logic [15:0] im;
		logic        sat;
	} gate_result_t;

	localparam gate_set_t GATE_HADAMARD = '{11585, 0, 11585, 0, 11585, 0, -11585, 0};
	localparam gate_set_t GATE_IDENTITY = '{16384, 0, 0, 0, 0, 0, 16384, 0};
	localparam gate_set_t GATE_PAULI_Y  = '{0, 0, 0, -16384, 0, 16384, 0, 0};
	localparam gate_set_t GATE_EXTREME  = '{32767, -32768, -32768, 32767,
		-32768, 32767, 32767, -32768};
	localparam gate_set_t GATE_ALL_MIN  = '{-32768, -32768, -32768, -32768,
		-32768, -32768, -32768, -32768};
	localparam gate_set_t GATE_ALL_MAX  = '{32767, 32767, 32767, 32767,
		32767, 32767, 32767, 32767};

	// DUT connections; every input is driven to a known value from time zero
	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              start = 1'b0;
	logic              busy;
	logic [1:0]        kind = '0;
	logic [9:0]        amp_index = '0;
	logic [3:0]        target_bit = '0;
	logic [15:0]       write_re = '0;
	logic [15:0]       write_im = '0;
	logic              done;
	logic [15:0]       read_re;
	logic [15:0]       read_im;
	logic              saturated;
	logic              psel = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [31:0]       pwdata = '0;
	logic [31:0]       prdata;
	logic              pready;

	// Predicted state
	logic [31:0]  amp_model [VEC_LEN];
	gate_set_t    coef_model;
	gate_result_t pending_results [$];

	// Bookkeeping
	int error_count     = 0;
	int results_checked = 0;
	int cmd_count       = 0;
	int apply_count     = 0;
	int sat_count       = 0;
	int gates_loaded    = 0;
	int sender_idle_pct = 15;
	int cycle_count     = 0;

	single_qubit_gate_apply #(
		.NUM_QUBITS(NQ)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.kind(kind),
		.amp_index(amp_index),
		.target_bit(target_bit),
		.write_re(write_re),
		.write_im(write_im),
		.done(done),
		.read_re(read_re),
		.read_im(read_im),
		.saturated(saturated),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always #6 clk = ~clk;

	// Watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding",
				cycle_count, pending_results.size());
			$display("** single_qubit_gate_apply: FAILED **");
			$finish;
		end
	end

	task automatic report_fail(input string msg);
		error_count++;
		if (error_count <= 40)
			$display("[%0t] mismatch: %s", $realtime, msg);
	endtask

	// Round to nearest, ties up, then clamp to Q2.14
	function automatic logic [15:0] round_q14(input longint acc, inout logic sat);
		longint r;
		r = (acc + 64'sd8192) >>> 14;
		if (r > 32767) begin
			sat = 1'b1;
			r = 32767;
		end
		if (r < -32768) begin
			sat = 1'b1;
			r = -32768;
		end
		return r[15:0];
	endfunction

	// One output amplitude of the gate: row starting at coefficient base
	function automatic logic [31:0] mix_row(input int base, input logic [31:0] a,
		input logic [31:0] b, inout logic sat);
		longint ar, ai, br, bi, car, cai, cbr, cbi;
		logic [15:0] out_re, out_im;
		ar  = longint'($signed(a[15:0]));
		ai  = longint'($signed(a[31:16]));
		br  = longint'($signed(b[15:0]));
		bi  = longint'($signed(b[31:16]));
		car = longint'(coef_model[base]);
		cai = longint'(coef_model[base + 1]);
		cbr = longint'(coef_model[base + 2]);
		cbi = longint'(coef_model[base + 3]);
		out_re = round_q14(car * ar - cai * ai + cbr * br - cbi * bi, sat);
		out_im = round_q14(car * ai + cai * ar + cbr * bi + cbi * br, sat);
		return {out_im, out_re};
	endfunction

	// Predict the result of one command and advance the state copy
	function automatic gate_result_t gate_predict(input gate_cmd_t c);
		gate_result_t r;
		int idx, mask, j;
		logic [31:0] a0, a1;
		logic sat;
		r = '0;
		idx = int'(c.amp_index) & (VEC_LEN - 1);
		case (c.kind)
			sqg_pkg::KIND_WRITE: amp_model[idx] = {c.write_im, c.write_re};
			sqg_pkg::KIND_READ: begin
				r.re = amp_model[idx][15:0];
				r.im = amp_model[idx][31:16];
			end
			sqg_pkg::KIND_APPLY: begin
				if (int'(c.target_bit) < NQ) begin
					mask = 1 << c.target_bit;
					sat = 1'b0;
					for (int i = 0; i < VEC_LEN; i++) begin
						if ((i & mask) == 0) begin
							j = i | mask;
							a0 = amp_model[i];
							a1 = amp_model[j];
							amp_model[i] = mix_row(REG_U00_RE, a0, a1, sat);
							amp_model[j] = mix_row(REG_U10_RE, a0, a1, sat);
						end
					end
					r.sat = sat;
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	// Result checker: one result per done strobe, in order
	always @(posedge clk) begin
		gate_result_t want;
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				report_fail($sformatf("result with nothing outstanding: re %h im %h sat %b",
					read_re, read_im, saturated));
			end else begin
				want = pending_results.pop_front();
				results_checked++;
				if (read_re !== want.re)
					report_fail($sformatf("read_re got %h expected %h", read_re, want.re));
				if (read_im !== want.im)
					report_fail($sformatf("read_im got %h expected %h", read_im, want.im));
				if (saturated !== want.sat)
					report_fail($sformatf("saturated got %b expected %b", saturated, want.sat));
			end
		end
	end

	function automatic gate_cmd_t make_cmd(input logic [1:0] k, input logic [9:0] idx,
		input logic [3:0] tbit, input logic [15:0] re, input logic [15:0] im);
		gate_cmd_t c;
		c.kind = k;
		c.amp_index = idx;
		c.target_bit = tbit;
		c.write_re = re;
		c.write_im = im;
		return c;
	endfunction

	function automatic logic [15:0] pick_extreme();
		case ($urandom_range(3))
			0: return 16'h8000;
			1: return 16'h7FFF;
			2: return 16'h0000;
			default: return 16'hFFFF;
		endcase
	endfunction

	// Send one command; called and left at a falling edge
	task automatic issue(input gate_cmd_t c);
		int gap;
		gate_result_t res;
		gap = 0;
		while (gap < MAX_GAP && $urandom_range(99) < sender_idle_pct)
			gap++;
		if (gap > 0 || busy) begin
			start <= 1'b0;
			repeat (gap) @(negedge clk);
			while (busy) @(negedge clk);
		end
		start      <= 1'b1;
		kind       <= c.kind;
		amp_index  <= c.amp_index;
		target_bit <= c.target_bit;
		write_re   <= c.write_re;
		write_im   <= c.write_im;
		// busy was low before this edge, so the transfer happens here
		@(posedge clk);
		res = gate_predict(c);
		pending_results.push_back(res);
		cmd_count++;
		if (c.kind == sqg_pkg::KIND_APPLY) apply_count++;
		if (res.sat) sat_count++;
		@(negedge clk);
	endtask

	// Drain all outstanding results, then let the block settle
	task automatic wait_idle();
		start <= 1'b0;
		while (pending_results.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic cfg_write(input int reg_idx, input q14_t val);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= ADDR_W'(4 * reg_idx);
		pwdata  <= {{16{val[15]}}, val};
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		coef_model[reg_idx] = val;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic cfg_check(input int reg_idx);
		logic [31:0] got;
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= ADDR_W'(4 * reg_idx);
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		got = prdata;
		if (got[15:0] !== coef_model[reg_idx])
			report_fail($sformatf("register %0d read %h expected %h",
				reg_idx, got[15:0], coef_model[reg_idx]));
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic load_gate(input gate_set_t g);
		wait_idle();
		for (int k = 0; k < NREGS; k++)
			cfg_write(k, g[k]);
		gates_loaded++;
	endtask

	task automatic load_random_gate();
		gate_set_t g;
		for (int k = 0; k < NREGS; k++)
			g[k] = q14_t'($urandom);
		load_gate(g);
	endtask

	function automatic gate_cmd_t random_cmd();
		gate_cmd_t c;
		int pick;
		c = make_cmd(KIND_NONE, 10'($urandom), 4'($urandom), 16'($urandom), 16'($urandom));
		pick = $urandom_range(99);
		if (pick < 40) begin
			c.kind = sqg_pkg::KIND_WRITE;
			if ($urandom_range(7) == 0) c.write_re = pick_extreme();
			if ($urandom_range(7) == 0) c.write_im = pick_extreme();
		end else if (pick < 75) begin
			c.kind = sqg_pkg::KIND_READ;
		end else if (pick < 94) begin
			c.kind = sqg_pkg::KIND_APPLY;
			if ($urandom_range(9) != 0)
				c.target_bit = 4'($urandom_range(NQ - 1));
			else
				c.target_bit = 4'($urandom_range(15, NQ));
		end
		return c;
	endfunction

	// Every amplitude written before anything reads it
	task automatic test_fill_store();
		logic [15:0] re, im;
		for (int i = 0; i < VEC_LEN; i++) begin
			re = (i < 4) ? pick_extreme() : 16'($urandom);
			im = (i < 4) ? pick_extreme() : 16'($urandom);
			issue(make_cmd(sqg_pkg::KIND_WRITE, 10'(i), 4'($urandom), re, im));
		end
	endtask

	// Writes and reads at the field extremes, the top index and the unused kind
	task automatic test_amp_access();
		issue(make_cmd(sqg_pkg::KIND_WRITE, 10'd0, 4'd0, 16'h7FFF, 16'h8000));
		issue(make_cmd(sqg_pkg::KIND_READ, 10'd0, 4'hF, 16'hFFFF, 16'hFFFF));
		issue(make_cmd(sqg_pkg::KIND_WRITE, 10'h3FF, 4'hF, 16'h8000, 16'h7FFF));
		issue(make_cmd(sqg_pkg::KIND_READ, 10'(VEC_LEN - 1), 4'd0, 16'h0000, 16'h0000));
		issue(make_cmd(sqg_pkg::KIND_READ, 10'h3FF, 4'd0, 16'h0000, 16'h0000));
		issue(make_cmd(sqg_pkg::KIND_WRITE, 10'h2A5, 4'd3, 16'hFFFF, 16'h0001));
		issue(make_cmd(sqg_pkg::KIND_READ, 10'h2A5 & 10'(VEC_LEN - 1), 4'd3, 16'h0, 16'h0));
		issue(make_cmd(KIND_NONE, 10'h3FF, 4'hF, 16'hFFFF, 16'hFFFF));
		issue(make_cmd(KIND_NONE, 10'($urandom), 4'($urandom), 16'($urandom), 16'($urandom)));
	endtask

	// Applies on the lowest and highest qubit, targets past the vector, saturation
	task automatic test_gate_apply();
		issue(make_cmd(sqg_pkg::KIND_APPLY, 10'h3FF, 4'd0, 16'hFFFF, 16'hFFFF));
		issue(make_cmd(sqg_pkg::KIND_READ, 10'd0, 4'd0, 16'h0, 16'h0));
		issue(make_cmd(sqg_pkg::KIND_READ, 10'd1, 4'd0, 16'h0, 16'h0));
		issue(make_cmd(sqg_pkg::KIND_APPLY, 10'd0, 4'(NQ - 1), 16'h0, 16'h0));
		issue(make_cmd(sqg_pkg::KIND_READ, 10'(1 << (NQ - 1)), 4'd0, 16'h0, 16'h0));
		issue(make_cmd(sqg_pkg::KIND_APPLY, 10'd0, 4'(NQ), 16'h0, 16'h0));
		issue(make_cmd(sqg_pkg::KIND_APPLY, 10'd0, 4'hF, 16'h0, 16'h0));
		issue(make_cmd(sqg_pkg::KIND_READ, 10'd3, 4'd0, 16'h0, 16'h0));
		load_gate(GATE_EXTREME);
		issue(make_cmd(sqg_pkg::KIND_APPLY, 10'd0, 4'd2, 16'h0, 16'h0));
		issue(make_cmd(sqg_pkg::KIND_READ, 10'd4, 4'd0, 16'h0, 16'h0));
		issue(make_cmd(sqg_pkg::KIND_READ, 10'd7, 4'd0, 16'h0, 16'h0));
	endtask

	// Register write and read-back at both extremes, each followed by an apply
	task automatic test_config_port();
		load_gate(GATE_ALL_MIN);
		for (int k = 0; k < NREGS; k++) cfg_check(k);
		issue(make_cmd(sqg_pkg::KIND_APPLY, 10'd0, 4'd1, 16'h0, 16'h0));
		issue(make_cmd(sqg_pkg::KIND_READ, 10'd2, 4'd0, 16'h0, 16'h0));
		load_gate(GATE_ALL_MAX);
		for (int k = 0; k < NREGS; k++) cfg_check(k);
		issue(make_cmd(sqg_pkg::KIND_APPLY, 10'd0, 4'd3, 16'h0, 16'h0));
		issue(make_cmd(sqg_pkg::KIND_READ, 10'd9, 4'd0, 16'h0, 16'h0));
	endtask

	task automatic test_random_traffic(input int n);
		for (int i = 0; i < n; i++)
			issue(random_cmd());
	endtask

	initial begin
		coef_model = GATE_HADAMARD;
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		sender_idle_pct = 15;
		test_fill_store();
		test_amp_access();
		test_gate_apply();
		load_gate(GATE_HADAMARD);
		test_config_port();

		// Random traffic under three idling patterns and six gate settings
		load_gate(GATE_IDENTITY);
		test_random_traffic(134);
		load_random_gate();
		test_random_traffic(134);

		sender_idle_pct = 66;
		load_gate(GATE_PAULI_Y);
		test_random_traffic(134);
		load_gate(GATE_EXTREME);
		test_random_traffic(134);

		sender_idle_pct = 0;
		load_random_gate();
		test_random_traffic(134);
		load_gate(GATE_HADAMARD);
		test_random_traffic(134);

		wait_idle();
		repeat (8) @(negedge clk);

		$display("%0d commands sent (%0d gate applies, %0d saturating), %0d results checked",
			cmd_count, apply_count, sat_count, results_checked);
		$display("%0d gate settings loaded, sender idling 15%%, 66%% and none; %0d mismatches",
			gates_loaded, error_count);
		if (error_count == 0)
			$display("** single_qubit_gate_apply: PASSED **");
		else
			$display("** single_qubit_gate_apply: FAILED **");
		$finish;
	end

endmodule
